// File: src/dat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dat_pkg
// Character codes, grouping modes, register indexes and the result item
// type for the argument tokenizer.
// ----------------------------------------------------------------------------
package dat_pkg;

    // Register indexes
    localparam logic [1:0] REG_NORMAL_COMMAS  = 2'd0;
    localparam logic [1:0] REG_USE_QUOTES     = 2'd1;
    localparam logic [1:0] REG_USE_BRACES     = 2'd2;
    localparam logic [1:0] REG_STRIP_BRACKETS = 2'd3;

    // Grouping modes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_DOUBLE = 2'd1;
    localparam logic [1:0] QM_SINGLE = 2'd2;
    localparam logic [1:0] QM_BRACE  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // One result item
    typedef struct packed {
        logic       emit_char;
        logic [7:0] out_char;
        logic       token_end;
        logic       line_end;
    } t_result;

endpackage : dat_pkg
`default_nettype wire

// File: src/delimited_argument_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_argument_tokenizer
// Each result is registered in the main output entry, or in the skid entry.
// Throughput: one character per cycle unless the skid is full; the tokenizer
// state updates in the same cycle as the character is taken, and a two-entry
// output register (main plus skid) keeps the input open while one result is stalled.
// Reset: synchronous active-low; clears modes, tokenizer state and valid flags.
// ----------------------------------------------------------------------------
// Splits a text line into arguments, one character per item, reporting the
// character to append, argument completion and end of line.
// ----------------------------------------------------------------------------
module delimited_argument_tokenizer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration
    input  wire                   i_cfg_we,
    input  wire  [1:0]            i_cfg_idx,
    input  wire  [0:0]            i_cfg_data,
    // input channel
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [7:0]            i_ch,
    input  wire                   i_last_in_line,
    // output channel
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic                  o_emit_char,
    output logic [7:0]            o_out_char,
    output logic                  o_token_end,
    output logic                  o_line_end
);
    import dat_pkg::*;

    // Mode registers
    logic r_normal_commas, r_use_quotes, r_use_braces, r_strip_brackets;

    // Tokenizer state
    logic [1:0] r_qm, n_qm;
    logic       r_has, n_has;
    logic       r_fresh, n_fresh;
    logic       r_skip, n_skip;

    // Output stages
    t_result r_out, r_skid, n_res;
    logic    r_ov, r_sv;

    logic in_acc, out_take;

    assign o_stall  = r_sv;
    assign in_acc   = i_valid && !r_sv;
    assign out_take = r_ov && !i_stall;

    // Write mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_commas  <= 1'b0;
            r_use_quotes     <= 1'b0;
            r_use_braces     <= 1'b0;
            r_strip_brackets <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NORMAL_COMMAS:  r_normal_commas  <= i_cfg_data[0];
                REG_USE_QUOTES:     r_use_quotes     <= i_cfg_data[0];
                REG_USE_BRACES:     r_use_braces     <= i_cfg_data[0];
                REG_STRIP_BRACKETS: r_strip_brackets <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the character and form the next state and result
    always_comb begin
        logic       done, eol, app, closed, has, tok;
        logic [1:0] qm, mine;
        done   = 1'b0;
        eol    = 1'b0;
        app    = 1'b0;
        closed = 1'b0;
        has    = 1'b0;
        tok    = 1'b0;
        qm     = r_qm;
        mine   = (i_ch == CH_DQUOTE) ? QM_DOUBLE : QM_SINGLE;
        n_res  = '0;
        n_qm   = r_qm;
        n_has  = r_has;
        n_fresh = r_fresh;
        n_skip = r_skip;

        if (r_skip) begin
            // ignore the rest of the line
            if (i_last_in_line) begin
                n_skip = 1'b0;
            end
        end else begin
            if (r_fresh && i_ch == CH_NUL) begin
                eol = 1'b1;
            end else begin
                case (i_ch) inside
                    CH_LF, CH_CR, CH_HASH: begin
                        done = 1'b1;
                        eol  = 1'b1;
                    end
                    CH_COMMA: begin
                        if (r_normal_commas || r_qm != QM_NONE) begin
                            app = 1'b1;
                        end else if (r_has) begin
                            done = 1'b1;
                        end
                    end
                    CH_TAB, CH_SPACE: begin
                        if (r_qm != QM_NONE) begin
                            app = 1'b1;
                        end else if (r_has) begin
                            done = 1'b1;
                        end
                    end
                    CH_DQUOTE, CH_SQUOTE: begin
                        if (r_use_quotes) begin
                            if (r_qm == QM_NONE) begin
                                qm = mine;
                            end else if (r_qm == mine) begin
                                qm     = QM_NONE;
                                closed = 1'b1;
                                done   = 1'b1;
                            end else begin
                                app = 1'b1;
                            end
                        end
                    end
                    CH_LBRACE, CH_RBRACE: begin
                        if (!r_use_braces) begin
                            app = 1'b1;
                        end else if (r_qm == QM_BRACE && i_ch == CH_RBRACE) begin
                            qm = QM_NONE;
                        end else begin
                            app = (r_qm != QM_NONE);
                            if (i_ch == CH_LBRACE) begin
                                qm = QM_BRACE;
                            end
                        end
                    end
                    CH_LPAREN, CH_RPAREN: begin
                        app = !r_strip_brackets;
                    end
                    default: begin
                        app = 1'b1;
                    end
                endcase
            end

            if (i_last_in_line) begin
                eol = 1'b1;
            end
            has = r_has || app;
            tok = (done || eol) && (has || closed);

            // close the argument or carry it on
            if (done || eol) begin
                n_qm    = QM_NONE;
                n_has   = 1'b0;
                n_fresh = 1'b1;
            end else begin
                n_qm    = qm;
                n_has   = has;
                n_fresh = 1'b0;
            end
            n_skip = eol && !i_last_in_line;

            n_res.emit_char = app;
            n_res.out_char  = app ? i_ch : CH_NUL;
            n_res.token_end = tok;
            n_res.line_end  = eol;
        end
    end

    // Advance tokenizer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm    <= QM_NONE;
            r_has   <= 1'b0;
            r_fresh <= 1'b1;
            r_skip  <= 1'b0;
        end else if (in_acc) begin
            r_qm    <= n_qm;
            r_has   <= n_has;
            r_fresh <= n_fresh;
            r_skip  <= n_skip;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_take) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= in_acc;
            end
        end else if (in_acc) begin
            if (r_ov) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_sv ? r_skid : n_res;
        end else if (in_acc && !r_ov) begin
            r_out <= n_res;
        end
        if (in_acc && r_ov && !out_take) begin
            r_skid <= n_res;
        end
    end

    assign o_valid     = r_ov;
    assign o_emit_char = r_out.emit_char;
    assign o_out_char  = r_out.out_char;
    assign o_token_end = r_out.token_end;
    assign o_line_end  = r_out.line_end;

    // Checks
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held while main output empty");

    a_fresh_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> (!r_has && r_qm == QM_NONE))
        else $error("new argument starts with stale grouping state");

    a_skip_implies_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_fresh)
        else $error("line skipping while an argument is open");

    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_skip && !i_last_in_line) |=> r_skip)
        else $error("line skipping ended before the last character");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_emit_char) |-> (o_out_char == CH_NUL))
        else $error("character shown without emit");

endmodule : delimited_argument_tokenizer
`default_nettype wire
